// ===== design/haa_pkg.sv =====
// shared types, constants and angle helper functions for the hour angle to
// azimuth/altitude converter; no dependencies
package haa_pkg;

    localparam int ANGLE_BITS_DEF    = 16;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int DATA_W            = 34;
    localparam int QFRAC             = 30;
    localparam logic signed [DATA_W-1:0] CORDIC_K = DATA_W'(652032874);

    typedef struct packed {
        logic [15:0]        hour_angle;
        logic signed [15:0] declination;
    } in_t;

    typedef struct packed {
        logic [15:0]        azimuth;
        logic signed [15:0] altitude;
    } out_t;

    localparam logic [31:0] ATAN_TURN32 [0:31] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
    };

    // arctangent of 2^-i as a binary angle of ab bits, rounded half up
    function automatic logic [32:0] atan_step(input int i, input int ab);
        logic [32:0] t;
        int s;
        t = {1'b0, ATAN_TURN32[i % 32]};
        s = 32 - ab;
        if (s > 0) begin
            t = (t + (33'd1 << (s - 1))) >> s;
        end
        return t;
    endfunction

    // 16-bit binary angle to ab bits, truncating when narrowing
    function automatic logic [31:0] from16(input logic [15:0] v, input int ab);
        logic [63:0] t;
        t = {48'd0, v};
        if (ab >= 16) begin
            t = t << (ab - 16);
        end else begin
            t = t >> (16 - ab);
        end
        return t[31:0];
    endfunction

    // ab-bit binary angle back to 16 bits, rounding half up, wrapping
    function automatic logic [15:0] to16(input logic [31:0] a, input int ab);
        logic [32:0] t;
        t = {1'b0, a};
        if (ab > 16) begin
            t = (t + (33'd1 << (ab - 17))) >> (ab - 16);
        end else begin
            t = t << (16 - ab);
        end
        return t[15:0];
    endfunction

endpackage

// ===== design/haa_delay.sv =====
// fixed-length shift line with stall enable, keeps side data in step with
// the cordic pipelines; depends on nothing
module haa_delay #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [WIDTH-1:0] in_data,
    output logic [WIDTH-1:0] out_data
);

    logic [WIDTH-1:0] tap_reg [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            tap_reg[0] <= in_data;
        end
    end

    for (genvar i = 1; i < DEPTH; i++) begin : g_tap
        always_ff @(posedge aclk) begin
            if (en) begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign out_data = tap_reg[DEPTH-1];

endmodule

// ===== design/haa_rotate.sv =====
// pipelined rotation-mode cordic: binary angle in, cosine and sine out (Q30)
// depends on haa_pkg
module haa_rotate #(
    parameter int ANGLE_BITS    = haa_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STAGES = haa_pkg::CORDIC_STAGES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [ANGLE_BITS-1:0]             in_angle,
    output logic                              out_valid,
    output logic signed [haa_pkg::DATA_W-1:0] out_cos,
    output logic signed [haa_pkg::DATA_W-1:0] out_sin
);

    localparam int AB = ANGLE_BITS;
    localparam int NS = CORDIC_STAGES;
    localparam int DW = haa_pkg::DATA_W;
    localparam logic [AB:0] QTR  = (AB+1)'(1) << (AB - 2);
    localparam logic [AB:0] HALF = (AB+1)'(1) << (AB - 1);

    logic          fold;
    logic [AB-1:0] ang_fold;

    logic                 v_reg   [0:NS];
    logic                 neg_reg [0:NS];
    logic signed [DW-1:0] x_reg   [0:NS];
    logic signed [DW-1:0] y_reg   [0:NS];
    logic [AB-1:0]        a_reg   [0:NS];
    logic                 out_valid_reg;
    logic signed [DW-1:0] cos_reg;
    logic signed [DW-1:0] sin_reg;

    // beyond a quarter turn: rotate by half a turn and negate at the end
    always_comb begin
        fold     = ({1'b0, in_angle} > QTR) && ({1'b0, in_angle} < HALF + QTR);
        ang_fold = fold ? (in_angle - HALF[AB-1:0]) : in_angle;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]   <= haa_pkg::CORDIC_K;
            y_reg[0]   <= '0;
            a_reg[0]   <= ang_fold;
            neg_reg[0] <= fold;
        end
    end

    for (genvar i = 0; i < NS; i++) begin : g_stage
        localparam logic [AB-1:0] STEP = AB'(haa_pkg::atan_step(i, AB));

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i+1] <= 1'b0;
            end else if (en) begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                neg_reg[i+1] <= neg_reg[i];
                if (a_reg[i][AB-1]) begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    a_reg[i+1] <= a_reg[i] + STEP;
                end else begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    a_reg[i+1] <= a_reg[i] - STEP;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= v_reg[NS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cos_reg <= neg_reg[NS] ? -x_reg[NS] : x_reg[NS];
            sin_reg <= neg_reg[NS] ? -y_reg[NS] : y_reg[NS];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_cos   = cos_reg;
    assign out_sin   = sin_reg;

endmodule

// ===== design/haa_vector.sv =====
// pipelined vectoring-mode cordic: (x, y) in, atan2 angle and scaled
// magnitude out; depends on haa_pkg
module haa_vector #(
    parameter int ANGLE_BITS    = haa_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STAGES = haa_pkg::CORDIC_STAGES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [haa_pkg::DATA_W-1:0] in_x,
    input  logic signed [haa_pkg::DATA_W-1:0] in_y,
    output logic                              out_valid,
    output logic [ANGLE_BITS-1:0]             out_angle,
    output logic signed [haa_pkg::DATA_W-1:0] out_mag
);

    localparam int AB = ANGLE_BITS;
    localparam int NS = CORDIC_STAGES;
    localparam int DW = haa_pkg::DATA_W;
    localparam logic [AB-1:0] HALF = AB'(1) << (AB - 1);

    logic                   v_reg    [0:NS];
    logic                   zero_reg [0:NS];
    logic signed [DW-1:0]   x_reg    [0:NS];
    logic signed [DW-1:0]   y_reg    [0:NS];
    logic [AB-1:0]          a_reg    [0:NS];
    logic                   out_valid_reg;
    logic [AB-1:0]          angle_reg;
    logic signed [DW-1:0]   mag_reg;
    logic signed [2*DW-1:0] mag_prod;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
        end
    end

    // left half plane is mirrored through the origin first
    always_ff @(posedge aclk) begin
        if (en) begin
            zero_reg[0] <= (in_x == '0) && (in_y == '0);
            if (in_x[DW-1]) begin
                x_reg[0] <= -in_x;
                y_reg[0] <= -in_y;
                a_reg[0] <= HALF;
            end else begin
                x_reg[0] <= in_x;
                y_reg[0] <= in_y;
                a_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < NS; i++) begin : g_stage
        localparam logic [AB-1:0] STEP = AB'(haa_pkg::atan_step(i, AB));

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i+1] <= 1'b0;
            end else if (en) begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                zero_reg[i+1] <= zero_reg[i];
                if (!y_reg[i][DW-1]) begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    a_reg[i+1] <= a_reg[i] + STEP;
                end else begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    a_reg[i+1] <= a_reg[i] - STEP;
                end
            end
        end
    end

    // gain correction, product floored back to Q30
    assign mag_prod = x_reg[NS] * haa_pkg::CORDIC_K;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= v_reg[NS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            angle_reg <= zero_reg[NS] ? '0 : a_reg[NS];
            mag_reg   <= zero_reg[NS] ? '0 : DW'(mag_prod >>> haa_pkg::QFRAC);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_angle = angle_reg;
    assign out_mag   = mag_reg;

endmodule

// ===== design/haa_horiz.sv =====
// two-stage multiply network forming the horizontal components X, Y, Z
// depends on haa_pkg
module haa_horiz (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [haa_pkg::DATA_W-1:0] ch,
    input  logic signed [haa_pkg::DATA_W-1:0] sh,
    input  logic signed [haa_pkg::DATA_W-1:0] cd,
    input  logic signed [haa_pkg::DATA_W-1:0] sd,
    input  logic signed [haa_pkg::DATA_W-1:0] cl,
    input  logic signed [haa_pkg::DATA_W-1:0] sl,
    output logic                              out_valid,
    output logic signed [haa_pkg::DATA_W-1:0] hx,
    output logic signed [haa_pkg::DATA_W-1:0] hy,
    output logic signed [haa_pkg::DATA_W-1:0] hz
);

    localparam int DW = haa_pkg::DATA_W;
    localparam int QF = haa_pkg::QFRAC;

    logic signed [2*DW-1:0] p_cdch, p_clsd, p_slsd, p_cdsh, p_slc, p_clc;

    logic                 v1_reg, v2_reg;
    logic signed [DW-1:0] cdch_reg, clsd_reg, slsd_reg, hy1_reg, cl_reg, sl_reg;
    logic signed [DW-1:0] hx_reg, hy_reg, hz_reg;

    assign p_cdch = cd * ch;
    assign p_clsd = cl * sd;
    assign p_slsd = sl * sd;
    assign p_cdsh = cd * sh;
    assign p_slc  = sl_reg * cdch_reg;
    assign p_clc  = cl_reg * cdch_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cdch_reg <= DW'(p_cdch >>> QF);
            clsd_reg <= DW'(p_clsd >>> QF);
            slsd_reg <= DW'(p_slsd >>> QF);
            hy1_reg  <= DW'(p_cdsh >>> QF);
            cl_reg   <= cl;
            sl_reg   <= sl;
            hx_reg   <= DW'(p_slc >>> QF) - clsd_reg;
            hy_reg   <= hy1_reg;
            hz_reg   <= DW'(p_clc >>> QF) + slsd_reg;
        end
    end

    assign out_valid = v2_reg;
    assign hx        = hx_reg;
    assign hy        = hy_reg;
    assign hz        = hz_reg;

endmodule

// ===== design/hour_angle_to_azimuth_altitude_top.sv =====
// equatorial to horizontal conversion, top level
// depends on haa_pkg, haa_rotate, haa_horiz, haa_vector, haa_delay
//
// s_ channel: one transaction carries hour angle and declination (binary
// angles). m_ channel: one transaction per input with azimuth (from north
// towards east) and true altitude. cfg_ channel writes the latitude
// register; cfg_ready is always high, latitude resets to zero.
// The datapath is one pipeline: three rotation cordics in parallel, a
// two-stage multiply network, then two vectoring cordics in series and an
// output register. Throughput is one transaction per cycle while the
// receiver does not stall the output.
// Reset (aresetn low, synchronous) clears every valid bit, so the pipeline
// comes up empty. When the receiver holds m_ready low with a result waiting,
// the whole pipeline freezes and s_ready drops in the same cycle; nothing is
// lost or repeated. At the zenith the azimuth reads half a turn.
module hour_angle_to_azimuth_altitude_top #(
    parameter int ANGLE_BITS    = haa_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STAGES = haa_pkg::CORDIC_STAGES_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  haa_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output haa_pkg::out_t m_data,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [15:0]   cfg_wdata
);

    localparam int AB = ANGLE_BITS;
    localparam int NS = CORDIC_STAGES;
    localparam int DW = haa_pkg::DATA_W;
    localparam logic [AB-1:0] HALF = AB'(1) << (AB - 1);

    logic                 en;
    logic [15:0]          lat_reg;
    logic                 m_valid_reg;
    haa_pkg::out_t        m_data_reg;

    logic                 rot_valid, hz_valid, vec1_valid, vec2_valid;
    logic signed [DW-1:0] ch, sh, cd, sd, cl, sl;
    logic signed [DW-1:0] hx, hy, hz, hz_d, hmag, unused_mag;
    logic [AB-1:0]        az_raw, az_d, alt;

    assign en        = !m_valid_reg || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lat_reg <= '0;
        end else if (cfg_valid) begin
            lat_reg <= cfg_wdata;
        end
    end

    haa_rotate #(.ANGLE_BITS(AB), .CORDIC_STAGES(NS)) u_rot_h (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(s_valid && s_ready),
        .in_angle(AB'(haa_pkg::from16(s_data.hour_angle, AB))),
        .out_valid(rot_valid), .out_cos(ch), .out_sin(sh)
    );

    haa_rotate #(.ANGLE_BITS(AB), .CORDIC_STAGES(NS)) u_rot_d (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(s_valid && s_ready),
        .in_angle(AB'(haa_pkg::from16(s_data.declination, AB))),
        .out_valid(), .out_cos(cd), .out_sin(sd)
    );

    // the user keeps latitude static while items are in flight (the block does not enforce it); it rides along
    haa_rotate #(.ANGLE_BITS(AB), .CORDIC_STAGES(NS)) u_rot_l (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(s_valid && s_ready),
        .in_angle(AB'(haa_pkg::from16(lat_reg, AB))),
        .out_valid(), .out_cos(cl), .out_sin(sl)
    );

    haa_horiz u_horiz (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(rot_valid),
        .ch(ch), .sh(sh), .cd(cd), .sd(sd), .cl(cl), .sl(sl),
        .out_valid(hz_valid), .hx(hx), .hy(hy), .hz(hz)
    );

    haa_vector #(.ANGLE_BITS(AB), .CORDIC_STAGES(NS)) u_vec_az (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(hz_valid),
        .in_x(hx), .in_y(hy),
        .out_valid(vec1_valid), .out_angle(az_raw), .out_mag(hmag)
    );

    haa_delay #(.WIDTH(DW), .DEPTH(NS + 2)) u_dly_hz (
        .aclk(aclk), .en(en), .in_data(hz), .out_data(hz_d)
    );

    haa_vector #(.ANGLE_BITS(AB), .CORDIC_STAGES(NS)) u_vec_alt (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(vec1_valid),
        .in_x(hmag), .in_y(hz_d),
        .out_valid(vec2_valid), .out_angle(alt), .out_mag(unused_mag)
    );

    // azimuth measured from north: add half a turn
    haa_delay #(.WIDTH(AB), .DEPTH(NS + 2)) u_dly_az (
        .aclk(aclk), .en(en), .in_data(az_raw + HALF), .out_data(az_d)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= vec2_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg.azimuth  <= haa_pkg::to16(32'(az_d), AB);
            m_data_reg.altitude <= haa_pkg::to16(32'(alt), AB);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // a stalled output freezes the pipeline feeding it
    a_stall_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(vec2_valid) && $stable(hz_d) && $stable(alt))
        else $error("pipeline moved while output stalled");

    a_result_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        en && vec2_valid |=> m_valid)
        else $error("finished result did not reach the output register");

    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !vec2_valid |=> !m_valid)
        else $error("output repeated after being taken");

    a_zero_mag: assert property (@(posedge aclk) disable iff (!aresetn)
        unused_mag[DW-1] == 1'b0 || !vec2_valid)
        else $error("vectoring magnitude went negative");

endmodule

// ===== tb/haa_checker.sv =====
// result checker for the hour angle to azimuth/altitude converter
// watches the cfg_, s_ and m_ channels, predicts each result and compares it
// depends on haa_pkg
module haa_checker (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  logic          s_ready,
    input  haa_pkg::in_t  s_data,
    input  logic          m_valid,
    input  logic          m_ready,
    input  haa_pkg::out_t m_data,
    input  logic          cfg_valid,
    input  logic          cfg_ready,
    input  logic [15:0]   cfg_wdata,
    output int            fail_count,
    output int            pending
);

    localparam longint GAIN = 652032874;

    logic [15:0]   lat_q;
    haa_pkg::out_t expected_q[$];

    function automatic longint mulq(input longint a, input longint b);
        return (a * b) >>> 30;
    endfunction

    function automatic longint atan_bin(input int i);
        return (longint'(haa_pkg::ATAN_TURN32[i]) + 32768) >>> 16;
    endfunction

    function automatic void sin_cos(input logic [15:0] ang, output longint c,
                                    output longint s);
        longint x, y, nx;
        logic   flip;
        x = GAIN;
        y = 0;
        flip = 0;
        // fold the left half plane onto the right one
        if (ang > 16'd16384 && ang < 16'd49152) begin
            ang = ang - 16'h8000;
            flip = 1;
        end
        for (int i = 0; i < 16; i++) begin
            if (ang[15]) begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                ang = ang + 16'(atan_bin(i));
            end else begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                ang = ang - 16'(atan_bin(i));
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic void arc_tan2(input longint x, input longint y,
                                     output logic [15:0] ang, output longint mag);
        longint nx;
        ang = 16'd0;
        mag = 0;
        if (x == 0 && y == 0) return;
        if (x < 0) begin
            x = -x;
            y = -y;
            ang = 16'h8000;
        end
        for (int i = 0; i < 16; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                ang = ang + 16'(atan_bin(i));
            end else begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                ang = ang - 16'(atan_bin(i));
            end
            x = nx;
        end
        mag = mulq(x, GAIN);
    endfunction

    function automatic haa_pkg::out_t horizon(input haa_pkg::in_t item,
                                              input logic [15:0] lat);
        longint ch, sh, cd, sd, cl, sl, cdch, hx, hy, hz, hmag, dummy;
        logic [15:0] az, alt;
        haa_pkg::out_t r;
        sin_cos(item.hour_angle, ch, sh);
        sin_cos(item.declination, cd, sd);
        sin_cos(lat, cl, sl);
        cdch = mulq(cd, ch);
        hx = mulq(sl, cdch) - mulq(cl, sd);
        hy = mulq(cd, sh);
        hz = mulq(cl, cdch) + mulq(sl, sd);
        arc_tan2(hx, hy, az, hmag);
        arc_tan2(hmag, hz, alt, dummy);
        r.azimuth = az + 16'h8000;
        r.altitude = alt;
        return r;
    endfunction

    assign pending = expected_q.size();

    always @(posedge aclk) begin
        haa_pkg::out_t want;
        if (!aresetn) begin
            lat_q <= 16'd0;
            fail_count <= 0;
            expected_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) lat_q <= cfg_wdata;
            if (s_valid && s_ready) expected_q.push_back(horizon(s_data, lat_q));
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result az=%0d alt=%0d",
                                 m_data.azimuth, m_data.altitude);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (want.azimuth !== m_data.azimuth
                            || want.altitude !== m_data.altitude) begin
                        if (fail_count < 10)
                            $display("mismatch: expected az=%0d alt=%0d, got az=%0d alt=%0d",
                                     want.azimuth, want.altitude,
                                     m_data.azimuth, m_data.altitude);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== tb/tb.sv =====
// testbench top for hour_angle_to_azimuth_altitude_top
// drives stimulus and latitude writes, haa_checker does the comparison
// depends on haa_pkg, haa_checker and the design
module tb;

    localparam int DRAIN = 3 * 16 + 30;

    logic          aclk;
    logic          aresetn;
    logic          s_valid;
    logic          s_ready;
    haa_pkg::in_t  s_data;
    logic          m_valid;
    logic          m_ready;
    haa_pkg::out_t m_data;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [15:0]   cfg_wdata;
    logic          steady;
    int            fail_count;
    int            pending;

    hour_angle_to_azimuth_altitude_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_wdata(cfg_wdata)
    );

    haa_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // receiver stalls at random unless in the steady stretch
    always @(posedge aclk) begin
        m_ready <= steady ? 1'b1 : ($urandom_range(99) >= 29);
    end

    task automatic send(input logic [15:0] ha, input logic [15:0] dec);
        while (!steady && $urandom_range(99) < 29) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data.hour_angle <= ha;
        s_data.declination <= dec;
        forever begin
            @(negedge aclk);
            if (s_ready) begin
                @(posedge aclk);
                break;
            end
            @(posedge aclk);
        end
    endtask

    task automatic quiesce();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    task automatic write_latitude(input logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_wdata <= v;
        forever begin
            @(negedge aclk);
            if (cfg_ready) begin
                @(posedge aclk);
                break;
            end
            @(posedge aclk);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic random_items(input int n);
        logic [15:0] dec;
        for (int i = 0; i < n; i++) begin
            // mostly in-range declinations, some wrapping bit patterns
            if ($urandom_range(9) < 8) dec = 16'($signed($urandom_range(32768)) - 16384);
            else dec = 16'($urandom);
            send(16'($urandom), dec);
        end
    endtask

    logic [15:0] lat_set[6] = '{16'd16384, 16'hC000, 16'd5461, 16'h7FFF, 16'h8000, 16'd0};
    logic [15:0] ha_dir[5] = '{16'd0, 16'd16384, 16'd32768, 16'd49152, 16'hFFFF};
    logic [15:0] dec_dir[5] = '{16'd0, 16'd16384, 16'hC000, 16'h7FFF, 16'h8000};

    initial begin
        aresetn = 0;
        s_valid = 0;
        s_data = '0;
        cfg_valid = 0;
        cfg_wdata = 16'd0;
        steady = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // extremes of both fields at reset latitude, zenith at ha 0 dec 0
        foreach (ha_dir[i]) send(ha_dir[i], dec_dir[i]);
        foreach (ha_dir[i]) send(ha_dir[i], dec_dir[(i + 2) % 5]);
        random_items(150);

        foreach (lat_set[p]) begin
            quiesce();
            write_latitude(lat_set[p]);
            steady <= (p == 2);
            // zenith at this latitude, then the same declination at hour angle half a turn
            send(16'd0, lat_set[p]);
            send(16'd32768, lat_set[p]);
            random_items(195);
        end
        steady <= 0;
        quiesce();

        if (fail_count == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ===== hour_angle_to_azimuth_altitude_top.f =====
design/haa_pkg.sv
design/haa_delay.sv
design/haa_rotate.sv
design/haa_vector.sv
design/haa_horiz.sv
design/hour_angle_to_azimuth_altitude_top.sv
tb/haa_checker.sv
tb/tb.sv
